### src/spt_pkg.sv
// ----------------------------------------------------------------------------
// spt_pkg: shared types and constants for the script push-data tokenizer
// Holds the parse phase codes, byte role codes, marker constants and the
// parser state and result structs.
// ----------------------------------------------------------------------------
package spt_pkg;

    localparam logic [7:0] MARK_PUSH2 = 8'd77;
    localparam logic [7:0] MARK_PUSH1 = 8'd76;
    localparam logic [7:0] MAX_DIRECT = 8'd75;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_LEN1    = 3'd1,
        PH_LEN2_LO = 3'd2,
        PH_LEN2_HI = 3'd3,
        PH_DATA    = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ROLE_OPCODE = 2'd0,
        ROLE_HEADER = 2'd1,
        ROLE_DATA   = 2'd2
    } role_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] bytes_left;
        logic [15:0] current_length;
        logic [7:0]  length_low_byte;
    } parse_state_t;

    typedef struct packed {
        role_t       byte_role;
        logic [7:0]  byte_value;
        logic        item_start;
        logic        item_done;
        logic [15:0] push_length;
        logic        truncated;
        logic        script_end;
    } result_t;

    localparam parse_state_t STATE_CLEAR = '{
        phase:           PH_IDLE,
        bytes_left:      16'd0,
        current_length:  16'd0,
        length_low_byte: 8'd0
    };

endpackage

### src/spt_step.sv
// ----------------------------------------------------------------------------
// spt_step: per-byte parse step
// Classifies one script byte against the current parser state and produces
// the result item and the next parser state.
// ----------------------------------------------------------------------------
module spt_step (
    input  spt_pkg::parse_state_t state,
    input  logic [7:0]            script_byte,
    input  logic                  last_in_script,
    output spt_pkg::parse_state_t state_next,
    output spt_pkg::result_t      result
);

    logic        len_known;
    logic [15:0] len_value;
    logic [15:0] left_dec;

    always_comb begin
        state_next = state;
        len_known  = 1'b0;
        len_value  = 16'd0;
        left_dec   = state.bytes_left;

        result.byte_role   = spt_pkg::ROLE_HEADER;
        result.byte_value  = script_byte;
        result.item_start  = 1'b0;
        result.item_done   = 1'b0;
        result.push_length = 16'd0;
        result.truncated   = 1'b0;
        result.script_end  = last_in_script;

        case (state.phase)
            spt_pkg::PH_LEN1: begin
                len_known = 1'b1;
                len_value = {8'd0, script_byte};
            end
            spt_pkg::PH_LEN2_LO: begin
                state_next.length_low_byte = script_byte;
                state_next.phase           = spt_pkg::PH_LEN2_HI;
            end
            spt_pkg::PH_LEN2_HI: begin
                len_known = 1'b1;
                len_value = {script_byte, state.length_low_byte};
            end
            spt_pkg::PH_DATA: begin
                result.byte_role   = spt_pkg::ROLE_DATA;
                result.push_length = state.current_length;
                if (state.bytes_left != 16'd0) begin
                    left_dec = state.bytes_left - 16'd1;
                end
                state_next.bytes_left = left_dec;
                if (left_dec == 16'd0) begin
                    result.item_done = 1'b1;
                    state_next       = spt_pkg::STATE_CLEAR;
                end
            end
            default: begin
                // Unused phase codes behave as idle: this byte opens an item.
                result.item_start = 1'b1;
                if (script_byte > spt_pkg::MARK_PUSH2) begin
                    result.byte_role = spt_pkg::ROLE_OPCODE;
                    result.item_done = 1'b1;
                    state_next       = spt_pkg::STATE_CLEAR;
                end else if (script_byte <= spt_pkg::MAX_DIRECT) begin
                    len_known = 1'b1;
                    len_value = {8'd0, script_byte};
                end else if (script_byte == spt_pkg::MARK_PUSH1) begin
                    state_next.phase = spt_pkg::PH_LEN1;
                end else begin
                    state_next.phase = spt_pkg::PH_LEN2_LO;
                end
            end
        endcase

        // A complete length either opens the data phase or ends an empty push.
        if (len_known) begin
            result.push_length        = len_value;
            state_next.current_length = len_value;
            state_next.bytes_left     = len_value;
            if (len_value == 16'd0) begin
                result.item_done = 1'b1;
                state_next       = spt_pkg::STATE_CLEAR;
            end else begin
                state_next.phase = spt_pkg::PH_DATA;
            end
        end

        if (last_in_script) begin
            result.truncated = ~result.item_done;
            state_next       = spt_pkg::STATE_CLEAR;
        end
    end

endmodule

### src/script_pushdata_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// script_pushdata_tokenizer_unit: script push-data tokenizer
// Splits a serialized script, taken one byte at a time, into opcode and push items
// and reports the role, boundaries and push length of every byte.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Payload
//  s_       in         s_valid / s_ready   script_byte, last_in_script
//  m_       out        m_valid / m_ready   byte_role, byte_value, item_start,
//                                          item_done, push_length, truncated,
//                                          script_end
//
// One byte is accepted per cycle while the output is not stalled; its result
// appears in the output register on the next cycle.
// The parser state update is a single step of logic between the state
// register and the result register.
// Reset clears the parser to idle and empties the output register.
// When the output is stalled, s_ready drops until the held result is taken.
// ----------------------------------------------------------------------------
module script_pushdata_tokenizer_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_script_byte,
    input  logic        s_last_in_script,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_byte_role,
    output logic [7:0]  m_byte_value,
    output logic        m_item_start,
    output logic        m_item_done,
    output logic [15:0] m_push_length,
    output logic        m_truncated,
    output logic        m_script_end
);

    spt_pkg::parse_state_t state_reg;
    spt_pkg::parse_state_t state_next;
    spt_pkg::result_t      result_reg;
    spt_pkg::result_t      result_next;
    logic                  m_valid_reg;
    logic                  accept;

    assign s_ready = ~m_valid_reg | m_ready;
    assign accept  = s_valid & s_ready;

    spt_step u_step (
        .state          (state_reg),
        .script_byte    (s_script_byte),
        .last_in_script (s_last_in_script),
        .state_next     (state_next),
        .result         (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= spt_pkg::STATE_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_byte_role   = result_reg.byte_role;
    assign m_byte_value  = result_reg.byte_value;
    assign m_item_start  = result_reg.item_start;
    assign m_item_done   = result_reg.item_done;
    assign m_push_length = result_reg.push_length;
    assign m_truncated   = result_reg.truncated;
    assign m_script_end  = result_reg.script_end;

endmodule

### sim/script_pushdata_tokenizer_unit_test.sv
// ----------------------------------------------------------------------------
// script_pushdata_tokenizer_unit_test: testbench for the script tokenizer
// Feeds opcode and push sequences, some cut short and some pure noise, into
// the tokenizer with random gaps and output stalls. Each result is checked
// field by field against a cycle-free model of the parser kept in the bench.
// ----------------------------------------------------------------------------
module script_pushdata_tokenizer_unit_test;

    localparam int CYCLE_LIMIT = 200000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_script_byte = 8'd0;
    logic        s_last_in_script = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_byte_role;
    logic [7:0]  m_byte_value;
    logic        m_item_start;
    logic        m_item_done;
    logic [15:0] m_push_length;
    logic        m_truncated;
    logic        m_script_end;

    spt_pkg::parse_state_t parser = spt_pkg::STATE_CLEAR;
    spt_pkg::result_t      expected_q[$];
    int                    idle_pct = 0;
    int                    bytes_sent = 0;
    int                    fail_count = 0;
    int                    cycle_count = 0;
    int                    stall_left = 0;

    script_pushdata_tokenizer_unit u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_script_byte    (s_script_byte),
        .s_last_in_script (s_last_in_script),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_byte_role      (m_byte_role),
        .m_byte_value     (m_byte_value),
        .m_item_start     (m_item_start),
        .m_item_done      (m_item_done),
        .m_push_length    (m_push_length),
        .m_truncated      (m_truncated),
        .m_script_end     (m_script_end)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Output stalls come in bursts that start at random, at a rate set by idle_pct.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            stall_left <= $urandom_range(0, 6);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Once the length is known, either the push is empty and done, or data follows.
    function automatic logic open_data(input logic [15:0] len);
        parser.current_length = len;
        parser.bytes_left = len;
        if (len == 16'd0) begin
            parser = spt_pkg::STATE_CLEAR;
            return 1'b1;
        end
        parser.phase = spt_pkg::PH_DATA;
        return 1'b0;
    endfunction

    task automatic tokenize_byte(input logic [7:0] b, input logic last,
                                 output spt_pkg::result_t r);
        logic [15:0] len;
        r = '0;
        r.byte_role = spt_pkg::ROLE_HEADER;
        r.byte_value = b;
        r.script_end = last;
        case (parser.phase)
            spt_pkg::PH_LEN1: begin
                len = {8'd0, b};
                r.push_length = len;
                r.item_done = open_data(len);
            end
            spt_pkg::PH_LEN2_LO: begin
                parser.length_low_byte = b;
                parser.phase = spt_pkg::PH_LEN2_HI;
            end
            spt_pkg::PH_LEN2_HI: begin
                len = {b, parser.length_low_byte};
                r.push_length = len;
                r.item_done = open_data(len);
            end
            spt_pkg::PH_DATA: begin
                r.byte_role = spt_pkg::ROLE_DATA;
                r.push_length = parser.current_length;
                if (parser.bytes_left != 16'd0)
                    parser.bytes_left = parser.bytes_left - 16'd1;
                if (parser.bytes_left == 16'd0) begin
                    r.item_done = 1'b1;
                    parser = spt_pkg::STATE_CLEAR;
                end
            end
            default: begin
                r.item_start = 1'b1;
                if (b > spt_pkg::MARK_PUSH2) begin
                    r.byte_role = spt_pkg::ROLE_OPCODE;
                    r.item_done = 1'b1;
                    parser = spt_pkg::STATE_CLEAR;
                end else if (b <= spt_pkg::MAX_DIRECT) begin
                    r.push_length = {8'd0, b};
                    r.item_done = open_data({8'd0, b});
                end else if (b == spt_pkg::MARK_PUSH1) begin
                    parser.phase = spt_pkg::PH_LEN1;
                end else begin
                    parser.phase = spt_pkg::PH_LEN2_LO;
                end
            end
        endcase
        if (last) begin
            r.truncated = !r.item_done;
            parser = spt_pkg::STATE_CLEAR;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        spt_pkg::result_t r;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_script_byte <= b;
        s_last_in_script <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tokenize_byte(b, last, r);
        expected_q = {expected_q, r};
        bytes_sent++;
    endtask

    always @(posedge aclk) begin : check_results
        spt_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $error("result with no item pending, byte_value %0h", m_byte_value);
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                if (m_byte_role !== want.byte_role) begin
                    $error("byte_role: expected %0d, actual %0d", want.byte_role, m_byte_role);
                    fail_count++;
                end
                if (m_byte_value !== want.byte_value) begin
                    $error("byte_value: expected %0h, actual %0h",
                           want.byte_value, m_byte_value);
                    fail_count++;
                end
                if (m_item_start !== want.item_start) begin
                    $error("item_start: expected %0b, actual %0b",
                           want.item_start, m_item_start);
                    fail_count++;
                end
                if (m_item_done !== want.item_done) begin
                    $error("item_done: expected %0b, actual %0b", want.item_done, m_item_done);
                    fail_count++;
                end
                if (m_push_length !== want.push_length) begin
                    $error("push_length: expected %0d, actual %0d",
                           want.push_length, m_push_length);
                    fail_count++;
                end
                if (m_truncated !== want.truncated) begin
                    $error("truncated: expected %0b, actual %0b", want.truncated, m_truncated);
                    fail_count++;
                end
                if (m_script_end !== want.script_end) begin
                    $error("script_end: expected %0b, actual %0b",
                           want.script_end, m_script_end);
                    fail_count++;
                end
            end
        end
    end

    // Single-byte opcodes, including the lowest one just above the long marker.
    task automatic test_opcodes();
        send_byte(8'd255, 1'b0);
        send_byte(8'd78, 1'b0);
    endtask

    task automatic test_direct_pushes();
        send_byte(8'd0, 1'b0);
        send_byte(8'd2, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    task automatic test_length_prefixed_pushes();
        send_byte(spt_pkg::MARK_PUSH1, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(spt_pkg::MARK_PUSH1, 1'b0);
        send_byte(8'd1, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(spt_pkg::MARK_PUSH2, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(spt_pkg::MARK_PUSH2, 1'b0);
        send_byte(8'd1, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(8'h5A, 1'b0);
    endtask

    // Scripts that end inside an item and scripts that end on a finished item.
    task automatic test_script_end();
        send_byte(spt_pkg::MARK_PUSH2, 1'b0);
        send_byte(8'h34, 1'b1);
        send_byte(spt_pkg::MARK_PUSH2, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h11, 1'b1);
        send_byte(8'd5, 1'b0);
        send_byte(8'd1, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(8'd1, 1'b0);
        send_byte(8'h3C, 1'b1);
    endtask

    task automatic queue_byte(ref logic [7:0] script_q[$], input logic [7:0] b);
        script_q = {script_q, b};
    endtask

    task automatic append_item(ref logic [7:0] script_q[$]);
        int kind;
        int sel;
        int len;
        kind = $urandom_range(0, 3);
        sel = $urandom_range(0, 19);
        if (sel == 0)
            len = 0;
        else if (sel < 16)
            len = $urandom_range(1, 8);
        else if (sel < 19)
            len = $urandom_range(9, 75);
        else
            len = $urandom_range(76, 255);
        case (kind)
            0: queue_byte(script_q, 8'($urandom_range(78, 255)));
            1: begin
                if (len > 75)
                    len = 75;
                queue_byte(script_q, 8'(len));
            end
            2: begin
                queue_byte(script_q, spt_pkg::MARK_PUSH1);
                queue_byte(script_q, 8'(len));
            end
            default: begin
                // Now and then a push with a length above one byte.
                if (sel == 19 && $urandom_range(0, 3) == 0)
                    len = $urandom_range(256, 300);
                queue_byte(script_q, spt_pkg::MARK_PUSH2);
                queue_byte(script_q, len[7:0]);
                queue_byte(script_q, len[15:8]);
            end
        endcase
        if (kind != 0)
            repeat (len) queue_byte(script_q, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_scripts(input int target_total, input int pct);
        logic [7:0] script_q[$];
        int kind;
        idle_pct = pct;
        while (bytes_sent < target_total) begin
            script_q.delete();
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
                // Noise with script ends anywhere, closed by a final end.
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end else if (kind == 1) begin
                // Two-byte length push, script ends zero to three data bytes in.
                queue_byte(script_q, spt_pkg::MARK_PUSH2);
                queue_byte(script_q, 8'($urandom_range(0, 255)));
                queue_byte(script_q, 8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 3))
                    queue_byte(script_q, 8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 6)) append_item(script_q);
                // Some scripts are cut short at a random byte, often inside an item.
                if (kind <= 4 && script_q.size() > 1)
                    script_q = script_q[0 : $urandom_range(0, script_q.size() - 2)];
            end
            for (int i = 0; i < script_q.size(); i++)
                send_byte(script_q[i], i == script_q.size() - 1);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_opcodes();
        test_direct_pushes();
        test_length_prefixed_pushes();
        test_script_end();
        test_random_scripts(450, 30);
        test_random_scripts(560, 0);
        test_random_scripts(800, 15);
        test_random_scripts(950, 0);
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
